@@ hdl/sspn_pkg.sv @@
// ----------------------------------------------------------------------------
// sspn_pkg
// Shared types, constants and round functions of the small SPN CBC encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package sspn_pkg;

    localparam int BLOCK_W      = 32;
    localparam int KEY_DEPTH    = 32;
    localparam int KEY_ADDR_W   = $clog2(KEY_DEPTH);
    localparam int REQ_W        = 2;
    localparam int NIBBLES      = BLOCK_W / 4;
    localparam int NUM_ROUNDS_DEF = 31;

    // bit i (below the top bit) moves to (PERM_STEP * i) mod PERM_MOD
    localparam int PERM_MOD     = BLOCK_W - 1;
    localparam int PERM_STEP    = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_KEY_LOAD = 2'd0,
        REQ_START    = 2'd1,
        REQ_ENCRYPT  = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_type_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB,
        4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8,
        4'h4, 4'h7, 4'h1, 4'h2
    };

    // Controller to datapath commands
    typedef struct packed {
        logic                  key_write;
        logic                  load_iv;
        logic                  load_state;
        logic                  do_round;
        logic                  finish;
        logic [KEY_ADDR_W-1:0] key_addr;
    } sspn_cmd_t;

    function automatic logic [BLOCK_W-1:0] sub_nibbles(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int p = 0; p < NIBBLES; p++)
        begin
            y[4*p +: 4] = SBOX[x[4*p +: 4]];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] scatter_bits(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int i = 0; i < PERM_MOD; i++)
        begin
            y[(PERM_STEP * i) % PERM_MOD] = x[i];
        end
        y[BLOCK_W-1] = x[BLOCK_W-1];
        return y;
    endfunction

endpackage

`default_nettype wire

@@ hdl/sspn_if.sv @@
// ----------------------------------------------------------------------------
// sspn_if
// Valid/ready channels of the encryptor: request channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sspn_req_if;
    logic                           valid;
    logic                           ready;
    logic [sspn_pkg::REQ_W-1:0]     req_type;
    logic [sspn_pkg::KEY_ADDR_W-1:0] key_index;
    logic [sspn_pkg::BLOCK_W-1:0]   data_word;
    logic                           last_word;

    modport source (output valid, req_type, key_index, data_word, last_word,
                    input ready);
    modport sink   (input valid, req_type, key_index, data_word, last_word,
                    output ready);
endinterface

interface sspn_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sspn_pkg::BLOCK_W-1:0] cipher_word;
    logic                         is_vector;
    logic                         end_of_message;

    modport source (output valid, cipher_word, is_vector, end_of_message,
                    input ready);
    modport sink   (input valid, cipher_word, is_vector, end_of_message,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/sspn_ram.sv @@
// ----------------------------------------------------------------------------
// sspn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sspn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/sspn_datapath.sv @@
// ----------------------------------------------------------------------------
// sspn_datapath
// Round key store, cipher state, round unit and chain/result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sspn_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sspn_pkg::sspn_cmd_t               cmd,
    input  wire logic [sspn_pkg::KEY_ADDR_W-1:0]   key_index,
    input  wire logic [sspn_pkg::BLOCK_W-1:0]      data_word,
    input  wire logic                              last_word,
    output      logic [sspn_pkg::BLOCK_W-1:0]      cipher_word,
    output      logic                              is_vector,
    output      logic                              end_of_message
);

    logic [sspn_pkg::BLOCK_W-1:0] round_key;
    logic [sspn_pkg::BLOCK_W-1:0] keyed;
    logic [sspn_pkg::BLOCK_W-1:0] state_reg,  state_next;
    logic [sspn_pkg::BLOCK_W-1:0] chain_reg,  chain_next;
    logic                         last_reg,   last_next;
    logic                         vector_reg, vector_next;
    logic                         eom_reg,    eom_next;

    sspn_ram #(
        .WIDTH (sspn_pkg::BLOCK_W),
        .DEPTH (sspn_pkg::KEY_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.key_write),
        .wr_addr (key_index),
        .wr_data (data_word),
        .rd_addr (cmd.key_addr),
        .rd_data (round_key)
    );

    assign keyed = state_reg ^ round_key;

    always_comb
    begin
        state_next  = state_reg;
        chain_next  = chain_reg;
        last_next   = last_reg;
        vector_next = vector_reg;
        eom_next    = eom_reg;
        if (cmd.load_state)
        begin
            state_next = chain_reg ^ data_word;
            last_next  = last_word;
        end
        if (cmd.do_round)
        begin
            state_next = sspn_pkg::scatter_bits(sspn_pkg::sub_nibbles(keyed));
        end
        if (cmd.load_iv)
        begin
            chain_next  = data_word;
            vector_next = 1'b1;
            eom_next    = 1'b0;
        end
        if (cmd.finish)
        begin
            chain_next  = keyed;
            vector_next = 1'b0;
            eom_next    = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg  <= state_next;
        last_reg   <= last_next;
        vector_reg <= vector_next;
        eom_reg    <= eom_next;
    end

    assign cipher_word    = chain_reg;
    assign is_vector      = vector_reg;
    assign end_of_message = eom_reg;

endmodule

`default_nettype wire

@@ hdl/sspn_ctrl.sv @@
// ----------------------------------------------------------------------------
// sspn_ctrl
// Request decode, round sequencer and result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sspn_ctrl #(
    parameter int NUM_ROUNDS = sspn_pkg::NUM_ROUNDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [sspn_pkg::REQ_W-1:0]    req_type,
    output      logic                          in_ready,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      sspn_pkg::sspn_cmd_t           cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ROUND = 3'b010,
        S_FINAL = 3'b100
    } state_t;

    localparam logic [sspn_pkg::KEY_ADDR_W-1:0] LAST_ROUND =
        sspn_pkg::KEY_ADDR_W'(NUM_ROUNDS - 1);
    localparam logic [sspn_pkg::KEY_ADDR_W-1:0] ROUND_STEP =
        sspn_pkg::KEY_ADDR_W'(1);

    state_t                          state_reg, state_next;
    logic [sspn_pkg::KEY_ADDR_W-1:0] round_reg, round_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_free;
    logic                            accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        round_next     = round_reg;
        case (state_reg)
            S_IDLE:
            begin
                round_next = '0;
                if (accept)
                begin
                    case (req_type)
                        sspn_pkg::REQ_KEY_LOAD: cmd.key_write = 1'b1;
                        sspn_pkg::REQ_START:    cmd.load_iv   = 1'b1;
                        sspn_pkg::REQ_ENCRYPT:
                        begin
                            cmd.load_state = 1'b1;
                            state_next     = S_ROUND;
                        end
                        default: ;
                    endcase
                end
            end
            S_ROUND:
            begin
                cmd.do_round = 1'b1;
                round_next   = round_reg + ROUND_STEP;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                cmd.finish = 1'b1;
                round_next = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                round_next = '0;
                state_next = S_IDLE;
            end
        endcase
        // drive the key address from round_next so the registered key RAM read matches the round in use
        cmd.key_addr   = round_next;
        out_valid_next = cmd.load_iv || cmd.finish || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_final_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) |-> !out_valid_reg)
        else $error("result slot occupied when round sequence finishes");

    a_final_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished block not presented as result");

    a_encrypt_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_state |=> (state_reg == S_ROUND && round_reg == '0))
        else $error("encrypt transfer did not start at round zero");

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && round_reg == LAST_ROUND) |=> (state_reg == S_FINAL))
        else $error("round count overran");
`endif

endmodule

`default_nettype wire

@@ hdl/small_spn_cbc_encryptor.sv @@
// ----------------------------------------------------------------------------
// small_spn_cbc_encryptor
// CBC-mode encryptor over a 32-bit SPN block cipher with loadable round keys.
//
//   channel | role   | transfer carries
//   --------+--------+--------------------------------------------------
//   req     | sink   | req_type, key_index, data_word, last_word
//   rsp     | source | cipher_word, is_vector, end_of_message
//
// Sequence: key load and start need no round sequence; an encrypt transfer
//   loads the state in the accept cycle, then runs one round per cycle and
//   ends with a final key XOR.
// Reset: rst_n clears the sequencer, the result flag and the chain value;
//   the key RAM has no reset, so keys are valid only once written.
// Stalls: req.ready is low while a block is in flight or a result waits untaken.
// ----------------------------------------------------------------------------
`default_nettype none

module small_spn_cbc_encryptor #(
    parameter int NUM_ROUNDS = sspn_pkg::NUM_ROUNDS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    sspn_req_if.sink   req,
    sspn_rsp_if.source rsp
);

    sspn_pkg::sspn_cmd_t cmd;

    // Sequencer: decode the request, step the rounds, hold the result flag.
    sspn_ctrl #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .req_type  (req.req_type),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath: key store, round state and chain; the chain register also
    // drives the result word.
    sspn_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .key_index      (req.key_index),
        .data_word      (req.data_word),
        .last_word      (req.last_word),
        .cipher_word    (rsp.cipher_word),
        .is_vector      (rsp.is_vector),
        .end_of_message (rsp.end_of_message)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_small_spn_cbc_encryptor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_small_spn_cbc_encryptor
// Self-checking bench for the CBC encryptor. It loads a full key schedule,
// then runs directed corner requests and random CBC messages. Request and
// result channels idle in several patterns, with one long result back-pressure
// stretch. Every result is compared against an in-bench cipher and chain
// predictor.
// ----------------------------------------------------------------------------
module tb_small_spn_cbc_encryptor;

    import sspn_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 900;
    localparam int PHASE_ITEMS  = 320;   // accepted transfers per idling phase
    localparam int HOLD_AT      = 2 * PHASE_ITEMS + 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;  // cycles without any transfer
    localparam int TAIL_CYCLES  = 40;    // covers one full encrypt
    localparam int MAX_PRINTS   = 30;
    localparam int ROUNDS       = NUM_ROUNDS_DEF;

    // 4-bit substitution applied to every nibble of the block
    localparam logic [3:0] NIB_MAP [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    typedef struct packed {
        req_type_t                kind;
        logic [KEY_ADDR_W-1:0]    slot;
        logic [BLOCK_W-1:0]       word;
        logic                     last;
    } cipher_req_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]       word;
        logic                     iv;
        logic                     eom;
    } cipher_out_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sspn_req_if req_ch ();
    sspn_rsp_if rsp_ch ();

    small_spn_cbc_encryptor uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Bench copy of the block state
    logic [BLOCK_W-1:0] key_copy [KEY_DEPTH];
    logic [BLOCK_W-1:0] chain_copy;

    cipher_req_t  pending_reqs [$];
    cipher_out_t  expected_words [$];
    cipher_req_t  in_flight;

    int accepted_cnt;
    int mismatch_cnt;
    int idle_cycles;
    int hold_left;
    bit hold_done;

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------------
    function automatic logic [BLOCK_W-1:0] nibble_subst(logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int p = 0; p < BLOCK_W / 4; p++)
        begin
            y[4*p +: 4] = NIB_MAP[x[4*p +: 4]];
        end
        return y;
    endfunction

    // bit i below the top moves to 8*i mod 31; the top bit stays put
    function automatic logic [BLOCK_W-1:0] bit_spread(logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int i = 0; i < BLOCK_W - 1; i++)
        begin
            y[(8 * i) % (BLOCK_W - 1)] = x[i];
        end
        y[BLOCK_W-1] = x[BLOCK_W-1];
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] spn_encrypt(logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] s;
        s = x;
        for (int r = 0; r < ROUNDS; r++)
        begin
            s = bit_spread(nibble_subst(s ^ key_copy[r % KEY_DEPTH]));
        end
        return s ^ key_copy[ROUNDS % KEY_DEPTH];
    endfunction

    // Advance the bench state by one accepted request and queue its result
    function automatic void apply_request(cipher_req_t it);
        case (it.kind)
            REQ_KEY_LOAD:
            begin
                key_copy[it.slot] = it.word;
            end
            REQ_START:
            begin
                chain_copy = it.word;
                expected_words.push_back('{word: chain_copy, iv: 1'b1, eom: 1'b0});
            end
            REQ_ENCRYPT:
            begin
                chain_copy = spn_encrypt(chain_copy ^ it.word);
                expected_words.push_back('{word: chain_copy, iv: 1'b0, eom: it.last});
            end
            default:
            begin
                // unknown request: no state change, no result
            end
        endcase
    endfunction

    function automatic int phase_of(int n);
        if (n < PHASE_ITEMS)
            return 0;
        else if (n < 2 * PHASE_ITEMS)
            return 1;
        return 2;
    endfunction

    task automatic report_mismatch(string what, logic [BLOCK_W-1:0] got,
                                   logic [BLOCK_W-1:0] want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic queue_req(req_type_t kind, logic [KEY_ADDR_W-1:0] slot,
                             logic [BLOCK_W-1:0] word, logic last);
        pending_reqs.push_back('{kind: kind, slot: slot, word: word, last: last});
    endtask

    // ------------------------------------------------------------------------
    // Request driver: hold the current transfer while ready is low, otherwise
    // pop the next pending item unless this cycle is drawn as an idle one.
    // Sender idle rate per phase: 16%, then 70%, then none.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        cipher_req_t nxt;
        logic        offer;
        int          idle_pct;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= '0;
            req_ch.key_index <= '0;
            req_ch.data_word <= '0;
            req_ch.last_word <= 1'b0;
        end
        else
        begin
            offer = 1'b0;
            nxt   = in_flight;
            case (phase_of(accepted_cnt))
                0:       idle_pct = 16;
                1:       idle_pct = 70;
                default: idle_pct = 0;
            endcase
            if (req_ch.valid && req_ch.ready)
            begin
                apply_request(in_flight);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                offer = 1'b1;
            end
            else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                nxt       = pending_reqs.pop_front();
                in_flight = nxt;
                offer     = 1'b1;
            end
            req_ch.valid <= offer;
            if (offer)
            begin
                req_ch.req_type  <= nxt.kind;
                req_ch.key_index <= nxt.slot;
                req_ch.data_word <= nxt.word;
                req_ch.last_word <= nxt.last;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long back-pressure stretch: once enough transfers went through, drop
    // result ready for HOLD_CYCLES while the sender keeps offering, so the
    // output register fills and the request side stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : backpressure_hold
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest expectation.
    // Receiver idle rate per phase: 70%, then 16%, then none.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        cipher_out_t want;
        int          idle_pct;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            case (phase_of(accepted_cnt))
                0:       idle_pct = 70;
                1:       idle_pct = 16;
                default: idle_pct = 0;
            endcase
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected result", rsp_ch.cipher_word, '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp_ch.cipher_word !== want.word)
                        report_mismatch("cipher_word", rsp_ch.cipher_word, want.word);
                    if (rsp_ch.is_vector !== want.iv)
                        report_mismatch("is_vector", BLOCK_W'(rsp_ch.is_vector),
                                        BLOCK_W'(want.iv));
                    if (rsp_ch.end_of_message !== want.eom)
                        report_mismatch("end_of_message",
                                        BLOCK_W'(rsp_ch.end_of_message),
                                        BLOCK_W'(want.eom));
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transfer happens for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : stall_watchdog
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int n_msg;
        int pick;
        int base;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = '0;
        req_ch.key_index = '0;
        req_ch.data_word = '0;
        req_ch.last_word = 1'b0;
        rsp_ch.ready     = 1'b0;
        chain_copy       = '0;
        accepted_cnt     = 0;
        mismatch_cnt     = 0;
        idle_cycles      = 0;

        // Write the whole key schedule first so no round ever reads an
        // unwritten slot; slot 0 and slot 31 take the extreme values.
        for (int k = 0; k < KEY_DEPTH; k++)
        begin
            if (k == 0)
                queue_req(REQ_KEY_LOAD, KEY_ADDR_W'(k), 32'h0000_0000, 1'b1);
            else if (k == KEY_DEPTH - 1)
                queue_req(REQ_KEY_LOAD, KEY_ADDR_W'(k), 32'hFFFF_FFFF, 1'b0);
            else
                queue_req(REQ_KEY_LOAD, KEY_ADDR_W'(k), $urandom,
                          1'($urandom_range(0, 1)));
        end

        // Encrypt before any start: chains from the reset value of zero
        queue_req(REQ_ENCRYPT, 5'd0,  32'h0000_0000, 1'b0);
        queue_req(REQ_ENCRYPT, 5'd31, 32'hFFFF_FFFF, 1'b1);
        // Unknown request with all fields high, then all low: ignored
        queue_req(REQ_UNUSED,  5'd31, 32'hFFFF_FFFF, 1'b1);
        // Start ignores last_word and reports end_of_message low
        queue_req(REQ_START,   5'd31, 32'hFFFF_FFFF, 1'b1);
        queue_req(REQ_ENCRYPT, 5'd0,  32'h0000_0000, 1'b0);
        queue_req(REQ_ENCRYPT, 5'd0,  32'hFFFF_FFFF, 1'b1);
        queue_req(REQ_START,   5'd0,  32'h0000_0000, 1'b0);
        queue_req(REQ_UNUSED,  5'd0,  32'h0000_0000, 1'b0);
        queue_req(REQ_ENCRYPT, 5'd17, $urandom,      1'b1);
        // Rekey the extreme slots the other way round and encrypt again
        queue_req(REQ_KEY_LOAD, 5'd31, 32'h0000_0000, 1'b1);
        queue_req(REQ_KEY_LOAD, 5'd0,  32'hFFFF_FFFF, 1'b0);
        queue_req(REQ_ENCRYPT,  5'd9,  32'hA5A5_5A5A, 1'b1);

        // Random part: mostly well-formed messages, the rest noise
        base = pending_reqs.size();
        while (pending_reqs.size() < base + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                n_msg = $urandom_range(1, 6);
                queue_req(REQ_START, KEY_ADDR_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
                for (int i = 0; i < n_msg; i++)
                begin
                    // mostly mark only the final word; flip the mark now and then
                    queue_req(REQ_ENCRYPT, KEY_ADDR_W'($urandom), $urandom,
                              (i == n_msg - 1) ^ ($urandom_range(0, 9) == 0));
                end
            end
            else if (pick < 80)
                queue_req(REQ_ENCRYPT, KEY_ADDR_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            else if (pick < 88)
                queue_req(REQ_KEY_LOAD, KEY_ADDR_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            else if (pick < 94)
                queue_req(REQ_UNUSED, KEY_ADDR_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            else
                queue_req(REQ_START, KEY_ADDR_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every request to be taken and every result to arrive,
        // then let the block settle in case of stray output
        while (pending_reqs.size() != 0 || req_ch.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        while (expected_words.size() != 0)
        begin
            report_mismatch("missing result", '0, expected_words[0].word);
            void'(expected_words.pop_front());
        end

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
